// File: sv/sfa_pkg.sv
package sfa_pkg;

  localparam int FREE_SLOTS_DEF  = 16;
  localparam int USED_SLOTS_DEF  = 16;
  localparam int BLOCK_SHIFT_DEF = 4;
  localparam int MAX_BLOCKS_DEF  = 4096;

  localparam int OP_W     = 2;
  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 16;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;
  localparam int BYTES_W  = 17;
  localparam int MODE_W   = 2;
  localparam int POOL_W   = 13;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_REINIT  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  localparam logic REG_FIT_MODE = 1'b0;
  localparam logic REG_POOL     = 1'b1;

  localparam logic [MODE_W-1:0] RESET_FIT_MODE = 2'd0;
  localparam logic [POOL_W-1:0] RESET_POOL     = 13'd4096;

  typedef struct packed {
    logic [MODE_W-1:0] fit_mode;
    logic [POOL_W-1:0] pool_blocks;
  } sfa_cfg_t;

endpackage

// File: sv/sfa_if.sv
interface sfa_req_if;
  logic                          valid;
  logic                          ready;
  logic [sfa_pkg::OP_W-1:0]      op;
  logic [sfa_pkg::SIZE_W-1:0]    size_bytes;
  logic [sfa_pkg::ADDR_W-1:0]    block_address;
  modport source(output valid, op, size_bytes, block_address, input ready);
  modport sink(input valid, op, size_bytes, block_address, output ready);
endinterface

interface sfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sfa_pkg::STATUS_W-1:0]  status;
  logic [sfa_pkg::ADDR_W-1:0]    address;
  logic [sfa_pkg::CNT_W-1:0]     free_count;
  logic [sfa_pkg::CNT_W-1:0]     used_count;
  logic [sfa_pkg::BYTES_W-1:0]   largest_free;
  logic [sfa_pkg::BYTES_W-1:0]   smallest_free;
  modport source(output valid, status, address, free_count, used_count, largest_free,
                 smallest_free, input ready);
  modport sink(input valid, status, address, free_count, used_count, largest_free,
               smallest_free, output ready);
endinterface

// File: sv/segment_fit_allocator.sv
// Block-granular pool allocator with first, smallest or biggest sufficient fit. One word is
// taken at a time and in_req.ready stays low until its result has been loaded into the output
// register. Every table access goes through a single read port per table, one entry a cycle,
// and every result ends with a scan of the free table for its statistics. An allocate that
// uses up the whole segment that it carves from also removes that entry from the free table,
// and when no segment fits, coalescing of adjacent free segments runs before a second search.
// Table occupancy and statistics come with every result.
module segment_fit_allocator #(
  parameter int FREE_SLOTS  = sfa_pkg::FREE_SLOTS_DEF,
  parameter int USED_SLOTS  = sfa_pkg::USED_SLOTS_DEF,
  parameter int BLOCK_SHIFT = sfa_pkg::BLOCK_SHIFT_DEF,
  parameter int MAX_BLOCKS  = sfa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sfa_req_if.sink                       in_req,
  sfa_rsp_if.source                     out_rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [sfa_pkg::DATA_W-1:0]    pwdata,
  output logic [sfa_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import sfa_pkg::*;

  localparam int FIW = $clog2(FREE_SLOTS);
  localparam int UIW = $clog2(USED_SLOTS);
  localparam int FCW = $clog2(FREE_SLOTS + 1);
  localparam int UCW = $clog2(USED_SLOTS + 1);
  localparam int KW  = (FCW > UCW) ? FCW : UCW;
  localparam int SW  = $clog2(MAX_BLOCKS);
  localparam int LW  = $clog2(MAX_BLOCKS + 1);
  localparam int NW  = SIZE_W + 1;
  localparam int CW  = (LW > NW) ? LW : NW;
  localparam int BW  = LW + BLOCK_SHIFT;
  localparam int AW  = SW + BLOCK_SHIFT + ADDR_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PICK  = 4'd1;
  localparam logic [3:0] S_COLD  = 4'd2;
  localparam logic [3:0] S_COSC  = 4'd3;
  localparam logic [3:0] S_FREM  = 4'd4;
  localparam logic [3:0] S_UINS  = 4'd5;
  localparam logic [3:0] S_USCAN = 4'd6;
  localparam logic [3:0] S_FINS  = 4'd7;
  localparam logic [3:0] S_UREM  = 4'd8;
  localparam logic [3:0] S_STATS = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  function automatic logic [LW-1:0] sat_pool(input logic [POOL_W-1:0] p);
    if (32'(p) > 32'(MAX_BLOCKS)) begin
      return LW'(MAX_BLOCKS);
    end
    return LW'(p);
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(input logic [SW-1:0] blk);
    logic [AW-1:0] wide;
    wide = AW'(blk) << BLOCK_SHIFT;
    return wide[ADDR_W-1:0];
  endfunction

  sfa_cfg_t cfg;

  sfa_apb u_apb (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  logic [3:0]          state_r, state_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic [FCW-1:0]      i_r, i_nxt, t_r, t_nxt;
  logic [FCW-1:0]      free_n_r, free_n_nxt;
  logic [UCW-1:0]      used_n_r, used_n_nxt;
  logic [FIW-1:0]      sel_r, sel_nxt;
  logic [UIW-1:0]      hit_r, hit_nxt;
  logic                found_r, found_nxt, retried_r, retried_nxt, ret_co_r, ret_co_nxt;
  logic [SW-1:0]       hold_start_r, hold_start_nxt;
  logic [LW-1:0]       hold_len_r, hold_len_nxt;
  logic [NW-1:0]       need_r, need_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [ADDR_W-1:0]   baddr_r, baddr_nxt, addr_r, addr_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [BW-1:0]       big_r, big_nxt, small_r, small_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] o_status_r, o_status_nxt;
  logic [ADDR_W-1:0]   o_addr_r, o_addr_nxt;
  logic [CNT_W-1:0]    o_fcnt_r, o_fcnt_nxt, o_ucnt_r, o_ucnt_nxt;
  logic [BYTES_W-1:0]  o_big_r, o_big_nxt, o_small_r, o_small_nxt;

  logic          fwe, uwe;
  logic [FIW-1:0] fwa, fra;
  logic [UIW-1:0] uwa, ura;
  logic [SW-1:0]  fws, uws, frs, urs;
  logic [LW-1:0]  fwl, uwl, frl, url;
  logic [KW-1:0]  k_up, k_dn;
  logic [NW-1:0]  in_need;
  logic [LW:0]    seg_end;
  logic [BW-1:0]  seg_bytes;
  logic           fits, accept;
  logic [LW-1:0]  rst_len;

  sfa_table #(.DEPTH(FREE_SLOTS), .SW(SW), .LW(LW)) u_free (
    .clk, .we(fwe), .waddr(fwa), .wstart(fws), .wlen(fwl), .raddr(fra),
    .rstart(frs), .rlen(frl)
  );

  sfa_table #(.DEPTH(USED_SLOTS), .SW(SW), .LW(LW)) u_used (
    .clk, .we(uwe), .waddr(uwa), .wstart(uws), .wlen(uwl), .raddr(ura),
    .rstart(urs), .rlen(url)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid & in_req.ready;
  assign k_up         = k_r + KW'(1);
  assign k_dn         = k_r - KW'(1);
  assign in_need      = (NW'(in_req.size_bytes) + NW'((1 << BLOCK_SHIFT) - 1)) >> BLOCK_SHIFT;
  assign seg_end      = (LW + 1)'(frs) + (LW + 1)'(frl);
  assign seg_bytes    = BW'(frl) << BLOCK_SHIFT;
  assign fits         = CW'(frl) >= CW'(need_r);
  assign rst_len      = sat_pool(RESET_POOL);

  always_comb begin
    unique case (state_r)
      S_COLD:  fra = i_r[FIW-1:0];
      S_COSC:  fra = t_r[FIW-1:0];
      S_FREM:  fra = k_up[FIW-1:0];
      S_FINS:  fra = k_dn[FIW-1:0];
      default: fra = k_r[FIW-1:0];
    endcase
    unique case (state_r)
      S_UINS:  ura = k_dn[UIW-1:0];
      S_UREM:  ura = k_up[UIW-1:0];
      default: ura = k_r[UIW-1:0];
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    t_nxt          = t_r;
    free_n_nxt     = free_n_r;
    used_n_nxt     = used_n_r;
    sel_nxt        = sel_r;
    hit_nxt        = hit_r;
    found_nxt      = found_r;
    retried_nxt    = retried_r;
    ret_co_nxt     = ret_co_r;
    hold_start_nxt = hold_start_r;
    hold_len_nxt   = hold_len_r;
    need_nxt       = need_r;
    op_nxt         = op_r;
    baddr_nxt      = baddr_r;
    addr_nxt       = addr_r;
    status_nxt     = status_r;
    big_nxt        = big_r;
    small_nxt      = small_r;
    out_valid_nxt  = out_valid_r & ~out_rsp.ready;
    o_status_nxt   = o_status_r;
    o_addr_nxt     = o_addr_r;
    o_fcnt_nxt     = o_fcnt_r;
    o_ucnt_nxt     = o_ucnt_r;
    o_big_nxt      = o_big_r;
    o_small_nxt    = o_small_r;
    fwe = 1'b0;
    fwa = '0;
    fws = '0;
    fwl = '0;
    uwe = 1'b0;
    uwa = '0;
    uws = '0;
    uwl = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_req.op;
          baddr_nxt   = in_req.block_address;
          need_nxt    = in_need;
          status_nxt  = ST_OK;
          addr_nxt    = '0;
          found_nxt   = 1'b0;
          retried_nxt = 1'b0;
          k_nxt       = '0;
          state_nxt   = S_STATS;
          unique case (in_req.op)
            OP_ALLOC: begin
              if (in_need == '0) begin
                status_nxt = ST_NOFIT;
              end else if (used_n_r >= UCW'(USED_SLOTS)) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_PICK;
              end
            end
            OP_RELEASE: state_nxt = S_USCAN;
            OP_REINIT: begin
              fwe        = 1'b1;
              fwl        = sat_pool(cfg.pool_blocks);
              free_n_nxt = FCW'(fwl != '0);
              used_n_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_PICK: begin
        if (k_r == KW'(free_n_r)) begin
          k_nxt = '0;
          if (found_r) begin
            k_nxt     = KW'(used_n_r);
            state_nxt = S_UINS;
          end else if (!retried_r) begin
            i_nxt     = '0;
            state_nxt = S_COLD;
          end else begin
            status_nxt = ST_NOFIT;
            state_nxt  = S_STATS;
          end
        end else begin
          k_nxt = k_up;
          if (fits) begin
            priority if (cfg.fit_mode == FIT_BEST) begin
              if (!found_r || frl < hold_len_r) begin
                found_nxt = 1'b1;
              end
            end else if (cfg.fit_mode == FIT_WORST) begin
              if (!found_r || frl > hold_len_r) begin
                found_nxt = 1'b1;
              end
            end else begin
              found_nxt = 1'b1;
              k_nxt     = KW'(used_n_r);
              state_nxt = S_UINS;
            end
            if (found_nxt != found_r || state_nxt == S_UINS || frl != hold_len_r) begin
              if (!found_r || state_nxt == S_UINS ||
                  (cfg.fit_mode == FIT_BEST && frl < hold_len_r) ||
                  (cfg.fit_mode == FIT_WORST && frl > hold_len_r)) begin
                sel_nxt        = k_r[FIW-1:0];
                hold_start_nxt = frs;
                hold_len_nxt   = frl;
              end
            end
          end
        end
      end
      S_COLD: begin
        if (i_r == free_n_r) begin
          retried_nxt = 1'b1;
          found_nxt   = 1'b0;
          k_nxt       = '0;
          state_nxt   = S_PICK;
        end else begin
          hold_start_nxt = frs;
          hold_len_nxt   = frl;
          t_nxt          = '0;
          state_nxt      = S_COSC;
        end
      end
      S_COSC: begin
        if (t_r == free_n_r) begin
          i_nxt     = i_r + FCW'(1);
          state_nxt = S_COLD;
        end else if (t_r != i_r && seg_end == (LW + 1)'(hold_start_r)) begin
          fwe        = 1'b1;
          fwa        = t_r[FIW-1:0];
          fws        = frs;
          fwl        = frl + hold_len_r;
          k_nxt      = KW'(i_r);
          ret_co_nxt = 1'b1;
          state_nxt  = S_FREM;
        end else begin
          t_nxt = t_r + FCW'(1);
        end
      end
      S_FREM: begin
        if (k_up < KW'(free_n_r)) begin
          fwe   = 1'b1;
          fwa   = k_r[FIW-1:0];
          fws   = frs;
          fwl   = frl;
          k_nxt = k_up;
        end else begin
          free_n_nxt = free_n_r - FCW'(1);
          k_nxt      = '0;
          state_nxt  = ret_co_r ? S_COLD : S_STATS;
        end
      end
      S_UINS: begin
        if (k_r != '0) begin
          uwe   = 1'b1;
          uwa   = k_r[UIW-1:0];
          uws   = urs;
          uwl   = url;
          k_nxt = k_dn;
        end else begin
          uwe        = 1'b1;
          uws        = hold_start_r;
          uwl        = LW'(need_r);
          used_n_nxt = used_n_r + UCW'(1);
          addr_nxt   = to_addr(hold_start_r);
          if (hold_len_r == LW'(need_r)) begin
            k_nxt      = KW'(sel_r);
            ret_co_nxt = 1'b0;
            state_nxt  = S_FREM;
          end else begin
            fwe       = 1'b1;
            fwa       = sel_r;
            fws       = hold_start_r + SW'(need_r);
            fwl       = hold_len_r - LW'(need_r);
            state_nxt = S_STATS;
          end
        end
      end
      S_USCAN: begin
        if (k_r == KW'(used_n_r)) begin
          status_nxt = ST_NOTFOUND;
          k_nxt      = '0;
          state_nxt  = S_STATS;
        end else if (to_addr(urs) == baddr_r) begin
          hit_nxt        = k_r[UIW-1:0];
          hold_start_nxt = urs;
          hold_len_nxt   = url;
          if (free_n_r >= FCW'(FREE_SLOTS)) begin
            status_nxt = ST_FULL;
            k_nxt      = '0;
            state_nxt  = S_STATS;
          end else begin
            k_nxt     = KW'(free_n_r);
            state_nxt = S_FINS;
          end
        end else begin
          k_nxt = k_up;
        end
      end
      S_FINS: begin
        if (k_r != '0) begin
          fwe   = 1'b1;
          fwa   = k_r[FIW-1:0];
          fws   = frs;
          fwl   = frl;
          k_nxt = k_dn;
        end else begin
          fwe        = 1'b1;
          fws        = hold_start_r;
          fwl        = hold_len_r;
          free_n_nxt = free_n_r + FCW'(1);
          k_nxt      = KW'(hit_r);
          state_nxt  = S_UREM;
        end
      end
      S_UREM: begin
        if (k_up < KW'(used_n_r)) begin
          uwe   = 1'b1;
          uwa   = k_r[UIW-1:0];
          uws   = urs;
          uwl   = url;
          k_nxt = k_up;
        end else begin
          used_n_nxt = used_n_r - UCW'(1);
          k_nxt      = '0;
          state_nxt  = S_STATS;
        end
      end
      S_STATS: begin
        if (k_r == KW'(free_n_r)) begin
          if (free_n_r == '0) begin
            big_nxt   = '0;
            small_nxt = '0;
          end
          state_nxt = S_OUT;
        end else begin
          if (k_r == '0 || seg_bytes > big_r) begin
            big_nxt = seg_bytes;
          end
          if (k_r == '0 || seg_bytes < small_r) begin
            small_nxt = seg_bytes;
          end
          k_nxt = k_up;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_addr_nxt    = addr_r;
          o_fcnt_nxt    = CNT_W'(free_n_r);
          o_ucnt_nxt    = CNT_W'(used_n_r);
          o_big_nxt     = BYTES_W'(big_r);
          o_small_nxt   = BYTES_W'(small_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (!rst_n) begin
      fwe = 1'b1;
      fwa = '0;
      fws = '0;
      fwl = rst_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_n_r    <= FCW'(rst_len != '0);
      used_n_r    <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      i_r         <= '0;
      t_r         <= '0;
      found_r     <= 1'b0;
      retried_r   <= 1'b0;
      ret_co_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_n_r    <= free_n_nxt;
      used_n_r    <= used_n_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      t_r         <= t_nxt;
      found_r     <= found_nxt;
      retried_r   <= retried_nxt;
      ret_co_r    <= ret_co_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r        <= sel_nxt;
    hit_r        <= hit_nxt;
    hold_start_r <= hold_start_nxt;
    hold_len_r   <= hold_len_nxt;
    need_r       <= need_nxt;
    op_r         <= op_nxt;
    baddr_r      <= baddr_nxt;
    addr_r       <= addr_nxt;
    status_r     <= status_nxt;
    big_r        <= big_nxt;
    small_r      <= small_nxt;
    o_status_r   <= o_status_nxt;
    o_addr_r     <= o_addr_nxt;
    o_fcnt_r     <= o_fcnt_nxt;
    o_ucnt_r     <= o_ucnt_nxt;
    o_big_r      <= o_big_nxt;
    o_small_r    <= o_small_nxt;
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = o_status_r;
  assign out_rsp.address       = o_addr_r;
  assign out_rsp.free_count    = o_fcnt_r;
  assign out_rsp.used_count    = o_ucnt_r;
  assign out_rsp.largest_free  = o_big_r;
  assign out_rsp.smallest_free = o_small_r;

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_n_r <= FCW'(FREE_SLOTS)) else $error("free table count out of range");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_n_r <= UCW'(USED_SLOTS)) else $error("used table count out of range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_req.ready) else $error("word accepted while busy");
  a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && status_r == ST_OK && op_r == OP_ALLOC) |->
    used_n_r != '0) else $error("allocate succeeded with empty used table");
`endif

endmodule

// File: sv/sfa_table.sv
module sfa_table #(
  parameter int DEPTH = 16,
  parameter int SW    = 12,
  parameter int LW    = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [SW-1:0]            wstart,
  input  logic [LW-1:0]            wlen,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [SW-1:0]            rstart,
  output logic [LW-1:0]            rlen
);

  logic [SW-1:0] start_r [DEPTH];
  logic [LW-1:0] len_r   [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      start_r[waddr] <= wstart;
      len_r[waddr]   <= wlen;
    end
  end

  assign rstart = start_r[raddr];
  assign rlen   = len_r[raddr];

endmodule

// File: sv/sfa_apb.sv
module sfa_apb (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [sfa_pkg::DATA_W-1:0]    pwdata,
  output logic [sfa_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output sfa_pkg::sfa_cfg_t             cfg
);
  import sfa_pkg::*;

  sfa_cfg_t cfg_r;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fit_mode    <= RESET_FIT_MODE;
      cfg_r.pool_blocks <= RESET_POOL;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_FIT_MODE: cfg_r.fit_mode    <= pwdata[MODE_W-1:0];
        REG_POOL:     cfg_r.pool_blocks <= pwdata[POOL_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FIT_MODE: prdata = DATA_W'(cfg_r.fit_mode);
      REG_POOL:     prdata = DATA_W'(cfg_r.pool_blocks);
      default:      prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
